@@ rtl/cau_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package cau_pkg;

  localparam int DW = 32;
  localparam int FW = 16;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 2;
  localparam int QW = SW - 1 + FW;
  localparam int RW = DW + 4;
  localparam int CW = $clog2(QW + 1);
  localparam int FD = 2;
  localparam int FPW = $clog2(FD);
  localparam int FCW = $clog2(FD + 1);

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_MAG = 3'd4,
    CMD_NEG = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_NEG,
    OP_MUL,
    OP_DIV,
    OP_MAG,
    OP_NONE,
    OP_DZ
  } op_e;

  typedef struct packed {
    op_e            op;
    logic [DW-1:0]  a;
    logic [DW-1:0]  b;
    logic [DW-1:0]  c;
    logic [DW-1:0]  d;
  } item_t;

  typedef struct packed {
    logic [DW-1:0] val;
    logic          ovf;
  } sat_t;

  function automatic logic signed [SW-1:0] ext_f(logic [DW-1:0] x);
    ext_f = $signed({{(SW-DW){x[DW-1]}}, x});
  endfunction

  function automatic logic [SW-2:0] mag_f(logic signed [SW-1:0] s);
    logic [SW-1:0] u;
    u = s[SW-1] ? (~s + SW'(1)) : s;
    mag_f = u[SW-2:0];
  endfunction

  function automatic sat_t sat_f(logic neg, logic [QW-1:0] mag);
    logic [QW-1:0] lim;
    sat_t r;
    lim = QW'(1) << (DW - 1);
    r.ovf = 1'b0;
    if (!neg) begin
      if (mag >= lim) begin
        r.val = {1'b0, {(DW-1){1'b1}}};
        r.ovf = 1'b1;
      end else begin
        r.val = mag[DW-1:0];
      end
    end else begin
      if (mag > lim) begin
        r.val = {1'b1, {(DW-1){1'b0}}};
        r.ovf = 1'b1;
      end else begin
        r.val = ~mag[DW-1:0] + DW'(1);
      end
    end
    sat_f = r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/complex_arithmetic_unit_core.sv @@
// add, subtract, negate, unused codes and divide by zero go from the queue head straight
// to the output register, one item per cycle while the output is not stalled; multiply,
// magnitude and divide hold the shared multiplier, then the digit-serial root or quotient
// loop, one item at a time, and short items wait while they run
// reset: asynchronous active low, clears the queue, the sequencer and the output valid
`timescale 1ns / 1ps
`default_nettype none
module complex_arithmetic_unit_core import cau_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [4*DW-1:0]   s_axis_tdata,  // x_re, x_im, y_re, y_im
  input  wire logic [2:0]        s_axis_tuser,  // cmd
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [2*DW-1:0]        m_axis_tdata,  // res_re, res_im
  output logic [1:0]             m_axis_tuser   // overflow, div_by_zero
);

  logic          full;
  logic          push;
  item_t         fitem;
  logic          fvalid;
  item_t         hitem;
  logic          pop;
  logic [DW-1:0] res_re;
  logic [DW-1:0] res_im;
  logic          ovf;
  logic          dz;

  cau_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .full_i        (full),
    .push_o        (push),
    .item_o        (fitem)
  );

  cau_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (fitem),
    .full_o  (full),
    .valid_o (fvalid),
    .item_o  (hitem),
    .pop_i   (pop)
  );

  cau_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (fvalid),
    .item_i    (hitem),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .res_re_o  (res_re),
    .res_im_o  (res_im),
    .ovf_o     (ovf),
    .dz_o      (dz)
  );

  assign m_axis_tdata = {res_im, res_re};
  assign m_axis_tuser = {dz, ovf};

`ifndef SYNTHESIS
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(ovf && dz))
    else $error("overflow and divide-by-zero both set");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && dz) |-> (res_re == '0 && res_im == '0))
    else $error("divide-by-zero result not zero");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !push)
    else $error("queue written while full");
`endif

endmodule
`default_nettype wire

@@ rtl/cau_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cau_front import cau_pkg::*; (
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [4*DW-1:0]   s_axis_tdata,
  input  wire logic [2:0]        s_axis_tuser,
  input  wire logic              full_i,
  output logic                   push_o,
  output item_t                  item_o
);

  logic [DW-1:0] yr;
  logic [DW-1:0] yi;

  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i;
  assign yr            = s_axis_tdata[3*DW-1:2*DW];
  assign yi            = s_axis_tdata[4*DW-1:3*DW];

  always_comb begin
    item_o.a = s_axis_tdata[DW-1:0];
    item_o.b = s_axis_tdata[2*DW-1:DW];
    item_o.c = yr;
    item_o.d = yi;
    unique case (cmd_e'(s_axis_tuser))
      CMD_ADD: item_o.op = OP_ADD;
      CMD_SUB: item_o.op = OP_SUB;
      CMD_MUL: item_o.op = OP_MUL;
      CMD_DIV: item_o.op = (yr == '0 && yi == '0) ? OP_DZ : OP_DIV;
      CMD_MAG: item_o.op = OP_MAG;
      CMD_NEG: item_o.op = OP_NEG;
      default: item_o.op = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/cau_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cau_fifo import cau_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  output logic       full_o,
  output logic       valid_o,
  output item_t      item_o,
  input  wire logic  pop_i
);

  item_t           mem_q [FD];
  logic [FPW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [FCW-1:0]  cnt_q, cnt_d;
  logic            do_pop;

  assign full_o  = (cnt_q == FCW'(FD));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == FPW'(FD - 1)) ? '0 : wr_q + FPW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == FPW'(FD - 1)) ? '0 : rd_q + FPW'(1);
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + FCW'(1);
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - FCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

@@ rtl/cau_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cau_back import cau_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire item_t           item_i,
  output logic                 pop_o,
  output logic                 m_valid_o,
  input  wire logic            m_ready_i,
  output logic [DW-1:0]        res_re_o,
  output logic [DW-1:0]        res_im_o,
  output logic                 ovf_o,
  output logic                 dz_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_FIN  = 5'b00100,
    S_DIV  = 5'b01000,
    S_SQRT = 5'b10000
  } state_e;

  typedef enum logic [1:0] {OPR_A, OPR_B, OPR_C, OPR_D} opr_e;
  typedef enum logic [1:0] {ACC_RE, ACC_IM, ACC_DEN} dst_e;

  typedef struct packed {
    opr_e x;
    opr_e y;
    dst_e dst;
    logic sub;
  } mstep_t;

  typedef struct packed {
    logic [PW-1:0] rem;
    logic [QW-1:0] num;
  } dlane_t;

  function automatic mstep_t mstep_f(op_e op, logic [2:0] step);
    mstep_t m;
    m = '{x: OPR_A, y: OPR_C, dst: ACC_RE, sub: 1'b0};
    unique case (op)
      OP_MUL: begin
        unique case (step)
          3'd1: m = '{x: OPR_B, y: OPR_D, dst: ACC_RE, sub: 1'b1};
          3'd2: m = '{x: OPR_B, y: OPR_C, dst: ACC_IM, sub: 1'b0};
          3'd3: m = '{x: OPR_A, y: OPR_D, dst: ACC_IM, sub: 1'b0};
          default: ;
        endcase
      end
      OP_DIV: begin
        unique case (step)
          3'd1: m = '{x: OPR_B, y: OPR_D, dst: ACC_RE, sub: 1'b0};
          3'd2: m = '{x: OPR_B, y: OPR_C, dst: ACC_IM, sub: 1'b0};
          3'd3: m = '{x: OPR_A, y: OPR_D, dst: ACC_IM, sub: 1'b1};
          3'd4: m = '{x: OPR_C, y: OPR_C, dst: ACC_DEN, sub: 1'b0};
          3'd5: m = '{x: OPR_D, y: OPR_D, dst: ACC_DEN, sub: 1'b0};
          default: ;
        endcase
      end
      default: begin
        unique case (step)
          3'd1: m = '{x: OPR_B, y: OPR_B, dst: ACC_RE, sub: 1'b0};
          default: m = '{x: OPR_A, y: OPR_A, dst: ACC_RE, sub: 1'b0};
        endcase
      end
    endcase
    mstep_f = m;
  endfunction

  function automatic dlane_t dstep_f(dlane_t l, logic [PW-1:0] den);
    logic [PW:0] t;
    dlane_t r;
    t = {l.rem, l.num[QW-1]};
    r.num = {l.num[QW-2:0], 1'b0};
    if (t >= {1'b0, den}) begin
      t = t - {1'b0, den};
      r.num[0] = 1'b1;
    end
    r.rem = t[PW-1:0];
    dstep_f = r;
  endfunction

  state_e                state_q, state_d;
  op_e                   op_q, op_d;
  logic [DW-1:0]         a_q, a_d, b_q, b_d, c_q, c_d, d_q, d_d;
  logic [2:0]            step_q, step_d;
  logic signed [PW-1:0]  prod_q, prod_d;
  logic                  pv_q, pv_d;
  dst_e                  dst_q, dst_d;
  logic                  sub_q, sub_d;
  logic signed [SW-1:0]  acc_re_q, acc_re_d, acc_im_q, acc_im_d, acc_den_q, acc_den_d;
  dlane_t                lre_q, lre_d, lim_q, lim_d;
  logic [PW-1:0]         den_q, den_d;
  logic                  neg_re_q, neg_re_d, neg_im_q, neg_im_d;
  logic [PW-1:0]         rad_q, rad_d;
  logic [DW-1:0]         root_q, root_d;
  logic [RW-1:0]         srem_q, srem_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  ovalid_q, ovalid_d;
  logic [DW-1:0]         ore_q, ore_d, oim_q, oim_d;
  logic                  oovf_q, oovf_d, odz_q, odz_d;

  logic                  out_free;
  logic [2:0]            nprod;
  mstep_t                ms;
  logic signed [DW-1:0]  mx, my;
  logic signed [SW-1:0]  pe, sre, sim;
  sat_t                  sr, si;
  logic [RW-1:0]         st, trial;

  function automatic logic [DW-1:0] opr_f(opr_e s, logic [DW-1:0] a, logic [DW-1:0] b,
                                          logic [DW-1:0] c, logic [DW-1:0] d);
    unique case (s)
      OPR_A: opr_f = a;
      OPR_B: opr_f = b;
      OPR_C: opr_f = c;
      default: opr_f = d;
    endcase
  endfunction

  assign out_free  = !ovalid_q || m_ready_i;
  assign m_valid_o = ovalid_q;
  assign res_re_o  = ore_q;
  assign res_im_o  = oim_q;
  assign ovf_o     = oovf_q;
  assign dz_o      = odz_q;

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    a_d       = a_q;
    b_d       = b_q;
    c_d       = c_q;
    d_d       = d_q;
    step_d    = step_q;
    prod_d    = prod_q;
    pv_d      = 1'b0;
    dst_d     = dst_q;
    sub_d     = sub_q;
    acc_re_d  = acc_re_q;
    acc_im_d  = acc_im_q;
    acc_den_d = acc_den_q;
    lre_d     = lre_q;
    lim_d     = lim_q;
    den_d     = den_q;
    neg_re_d  = neg_re_q;
    neg_im_d  = neg_im_q;
    rad_d     = rad_q;
    root_d    = root_q;
    srem_d    = srem_q;
    cnt_d     = cnt_q;
    ovalid_d  = ovalid_q && !m_ready_i;
    ore_d     = ore_q;
    oim_d     = oim_q;
    oovf_d    = oovf_q;
    odz_d     = odz_q;
    pop_o     = 1'b0;
    sre       = '0;
    sim       = '0;
    sr        = '0;
    si        = '0;
    pe        = {{(SW-PW){prod_q[PW-1]}}, prod_q};
    nprod     = (op_q == OP_MUL) ? 3'd4 : (op_q == OP_DIV) ? 3'd6 : 3'd2;
    ms        = mstep_f(op_q, step_q);
    mx        = opr_f(ms.x, a_q, b_q, c_q, d_q);
    my        = opr_f(ms.y, a_q, b_q, c_q, d_q);
    st        = {srem_q[RW-3:0], rad_q[PW-1:PW-2]};
    trial     = RW'({root_q, 2'b01});

    unique case (state_q)
      S_IDLE: begin
        if (valid_i) begin
          priority case (item_i.op)
            OP_MUL, OP_DIV, OP_MAG: begin
              pop_o     = 1'b1;
              op_d      = item_i.op;
              a_d       = item_i.a;
              b_d       = item_i.b;
              c_d       = item_i.c;
              d_d       = item_i.d;
              step_d    = '0;
              acc_re_d  = '0;
              acc_im_d  = '0;
              acc_den_d = '0;
              state_d   = S_MUL;
            end
            default: begin
              if (out_free) begin
                pop_o = 1'b1;
                priority case (item_i.op)
                  OP_ADD: begin
                    sre = ext_f(item_i.a) + ext_f(item_i.c);
                    sim = ext_f(item_i.b) + ext_f(item_i.d);
                  end
                  OP_SUB: begin
                    sre = ext_f(item_i.a) - ext_f(item_i.c);
                    sim = ext_f(item_i.b) - ext_f(item_i.d);
                  end
                  OP_NEG: begin
                    sre = -ext_f(item_i.a);
                    sim = -ext_f(item_i.b);
                  end
                  default: ;
                endcase
                sr       = sat_f(sre[SW-1], QW'(mag_f(sre)));
                si       = sat_f(sim[SW-1], QW'(mag_f(sim)));
                ovalid_d = 1'b1;
                ore_d    = sr.val;
                oim_d    = si.val;
                oovf_d   = sr.ovf | si.ovf;
                odz_d    = (item_i.op == OP_DZ);
              end
            end
          endcase
        end
      end
      S_MUL: begin
        if (pv_q) begin
          unique case (dst_q)
            ACC_RE:  acc_re_d  = sub_q ? acc_re_q - pe : acc_re_q + pe;
            ACC_IM:  acc_im_d  = sub_q ? acc_im_q - pe : acc_im_q + pe;
            ACC_DEN: acc_den_d = acc_den_q + pe;
            default: ;
          endcase
        end
        if (step_q < nprod) begin
          prod_d = mx * my;
          dst_d  = ms.dst;
          sub_d  = ms.sub;
          pv_d   = 1'b1;
          step_d = step_q + 3'd1;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        unique case (op_q)
          OP_MUL: begin
            if (out_free) begin
              sr       = sat_f(acc_re_q[SW-1], QW'(mag_f(acc_re_q) >> FW));
              si       = sat_f(acc_im_q[SW-1], QW'(mag_f(acc_im_q) >> FW));
              ovalid_d = 1'b1;
              ore_d    = sr.val;
              oim_d    = si.val;
              oovf_d   = sr.ovf | si.ovf;
              odz_d    = 1'b0;
              state_d  = S_IDLE;
            end
          end
          OP_DIV: begin
            lre_d.num = QW'(mag_f(acc_re_q)) << FW;
            lre_d.rem = '0;
            lim_d.num = QW'(mag_f(acc_im_q)) << FW;
            lim_d.rem = '0;
            neg_re_d  = acc_re_q[SW-1];
            neg_im_d  = acc_im_q[SW-1];
            den_d     = acc_den_q[PW-1:0];
            cnt_d     = CW'(QW);
            state_d   = S_DIV;
          end
          default: begin
            rad_d   = acc_re_q[PW-1:0];
            root_d  = '0;
            srem_d  = '0;
            cnt_d   = CW'(DW);
            state_d = S_SQRT;
          end
        endcase
      end
      S_DIV: begin
        if (cnt_q != '0) begin
          lre_d = dstep_f(lre_q, den_q);
          lim_d = dstep_f(lim_q, den_q);
          cnt_d = cnt_q - CW'(1);
        end else if (out_free) begin
          sr       = sat_f(neg_re_q, lre_q.num);
          si       = sat_f(neg_im_q, lim_q.num);
          ovalid_d = 1'b1;
          ore_d    = sr.val;
          oim_d    = si.val;
          oovf_d   = sr.ovf | si.ovf;
          odz_d    = 1'b0;
          state_d  = S_IDLE;
        end
      end
      S_SQRT: begin
        if (cnt_q != '0) begin
          rad_d = {rad_q[PW-3:0], 2'b00};
          if (st >= trial) begin
            srem_d = st - trial;
            root_d = {root_q[DW-2:0], 1'b1};
          end else begin
            srem_d = st;
            root_d = {root_q[DW-2:0], 1'b0};
          end
          cnt_d = cnt_q - CW'(1);
        end else if (out_free) begin
          sr       = sat_f(1'b0, QW'(root_q));
          ovalid_d = 1'b1;
          ore_d    = sr.val;
          oim_d    = '0;
          oovf_d   = sr.ovf;
          odz_d    = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
      pv_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      pv_q     <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    a_q       <= a_d;
    b_q       <= b_d;
    c_q       <= c_d;
    d_q       <= d_d;
    step_q    <= step_d;
    prod_q    <= prod_d;
    dst_q     <= dst_d;
    sub_q     <= sub_d;
    acc_re_q  <= acc_re_d;
    acc_im_q  <= acc_im_d;
    acc_den_q <= acc_den_d;
    lre_q     <= lre_d;
    lim_q     <= lim_d;
    den_q     <= den_d;
    neg_re_q  <= neg_re_d;
    neg_im_q  <= neg_im_d;
    rad_q     <= rad_d;
    root_q    <= root_d;
    srem_q    <= srem_d;
    cnt_q     <= cnt_d;
    ore_q     <= ore_d;
    oim_q     <= oim_d;
    oovf_q    <= oovf_d;
    odz_q     <= odz_d;
  end

endmodule
`default_nettype wire
